[design/mts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned DataW      = 32;
  localparam int unsigned EntryW     = 7;
  localparam int unsigned AddrW      = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned CntW       = $clog2(StackDepth + 1);

  localparam logic signed [DataW-1:0] EmptyMark = -'sd1;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_e;

  typedef enum logic {
    ST_IDLE,
    ST_POP_WAIT
  } state_e;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] min;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

[design/mts_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface mts_in_if;
  import mts_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [DataW-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface mts_out_if;
  import mts_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] top_value;
  logic signed [DataW-1:0] min_value;
  logic                    stack_empty;
  logic                    overflow;
  logic [EntryW-1:0]       entry_count;

  modport source (output valid, output top_value, output min_value, output stack_empty,
                  output overflow, output entry_count, input ready);
  modport sink   (input valid, input top_value, input min_value, input stack_empty,
                  input overflow, input entry_count, output ready);
endinterface

`default_nettype wire

[design/min_tracking_stack.sv]
// Channel | Direction | Payload
// in_i    | sink      | action (0 push, 1 pop), value (signed 32 bit)
// out_o   | source    | top_value, min_value, stack_empty, overflow, entry_count
//
// A push, a dropped push and a pop that leaves the stack empty load their result directly.
// A pop that leaves one or more entries first reads the new top from the entry memory,
// whose read port is registered, and loads its result from the ST_POP_WAIT state.
// Reset empties the stack; the entry memory itself is not cleared.
// The result register lets a new item in while the previous result is being taken;
// a held result blocks further input.
`timescale 1ns / 1ps
`default_nettype none

module min_tracking_stack (
  input  wire       clk_i,
  input  wire       rst_ni,
  mts_in_if.sink    in_i,
  mts_out_if.source out_o
);
  import mts_pkg::*;

  mem_req_t mem_req;
  entry_t   rd_data;

  mts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .mem_req_o (mem_req),
    .rd_data_i (rd_data)
  );

  mts_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

`ifndef SYNTH
  // A push that is not dropped shows its own value on top right away.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.action == ACT_PUSH)) |=>
      (out_o.valid && (out_o.overflow || (out_o.top_value == $past(in_i.value)))))
    else $error("push result does not show the pushed value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.stack_empty) |->
      ((out_o.entry_count == '0) && (out_o.top_value == EmptyMark)
       && (out_o.min_value == EmptyMark)))
    else $error("empty result is inconsistent");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.overflow) |->
      ((out_o.entry_count == EntryW'(StackDepth)) && !out_o.stack_empty))
    else $error("overflow flagged while not full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.stack_empty) |-> (out_o.min_value <= out_o.top_value))
    else $error("minimum exceeds top entry");
`endif

endmodule

`default_nettype wire

[design/mts_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module mts_mem (
  input  wire                    clk_i,
  input  wire mts_pkg::mem_req_t req_i,
  output mts_pkg::entry_t        rd_data_o
);
  import mts_pkg::*;

  entry_t mem_q [StackDepth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_o <= mem_q[req_i.raddr];
    end
  end

endmodule

`default_nettype wire

[design/mts_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module mts_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  mts_in_if.sink               in_i,
  mts_out_if.source            out_o,
  output mts_pkg::mem_req_t    mem_req_o,
  input  wire mts_pkg::entry_t rd_data_i
);
  import mts_pkg::*;

  state_e st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // The top entry is cached so that a push needs no memory read.
  logic signed [DataW-1:0] top_val_q, top_val_d;
  logic signed [DataW-1:0] top_min_q, top_min_d;

  logic                    out_valid_q, out_valid_d;
  logic signed [DataW-1:0] res_top_q, res_top_d;
  logic signed [DataW-1:0] res_min_q, res_min_d;
  logic                    res_empty_q, res_empty_d;
  logic                    res_ovf_q, res_ovf_d;
  logic [CntW-1:0]         res_cnt_q, res_cnt_d;

  logic                    in_ready;
  logic                    accept;
  logic                    load;
  logic                    is_full;
  logic [CntW-1:0]         cnt_inc;
  logic [CntW-1:0]         cnt_minus2;
  logic signed [DataW-1:0] new_min;

  assign in_ready   = (st_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_ready;
  assign is_full    = (cnt_q == CntW'(StackDepth));
  assign cnt_inc    = cnt_q + CntW'(1);
  assign cnt_minus2 = cnt_q - CntW'(2);
  assign new_min    = ((cnt_q != '0) && (top_min_q < in_i.value)) ? top_min_q : in_i.value;

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (accept && (in_i.action == ACT_POP) && (cnt_q >= CntW'(2))) begin
          st_d = ST_POP_WAIT;
        end
      end
      ST_POP_WAIT: begin
        st_d = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    cnt_d       = cnt_q;
    top_val_d   = top_val_q;
    top_min_d   = top_min_q;
    mem_req_o   = '0;
    load        = 1'b0;
    res_top_d   = res_top_q;
    res_min_d   = res_min_q;
    res_empty_d = res_empty_q;
    res_ovf_d   = res_ovf_q;
    res_cnt_d   = res_cnt_q;
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.action == ACT_PUSH) begin
            if (is_full) begin
              load        = 1'b1;
              res_top_d   = top_val_q;
              res_min_d   = top_min_q;
              res_empty_d = 1'b0;
              res_ovf_d   = 1'b1;
              res_cnt_d   = cnt_q;
            end else begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = cnt_q[AddrW-1:0];
              mem_req_o.wdata = '{value: in_i.value, min: new_min};
              cnt_d           = cnt_inc;
              top_val_d       = in_i.value;
              top_min_d       = new_min;
              load            = 1'b1;
              res_top_d       = in_i.value;
              res_min_d       = new_min;
              res_empty_d     = 1'b0;
              res_ovf_d       = 1'b0;
              res_cnt_d       = cnt_inc;
            end
          end else if (cnt_q >= CntW'(2)) begin
            // The new top lies in memory; its result is loaded from the read data in ST_POP_WAIT.
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = cnt_minus2[AddrW-1:0];
            cnt_d           = cnt_q - CntW'(1);
          end else begin
            cnt_d       = '0;
            load        = 1'b1;
            res_top_d   = EmptyMark;
            res_min_d   = EmptyMark;
            res_empty_d = 1'b1;
            res_ovf_d   = 1'b0;
            res_cnt_d   = '0;
          end
        end
      end
      ST_POP_WAIT: begin
        top_val_d   = rd_data_i.value;
        top_min_d   = rd_data_i.min;
        load        = 1'b1;
        res_top_d   = rd_data_i.value;
        res_min_d   = rd_data_i.min;
        res_empty_d = 1'b0;
        res_ovf_d   = 1'b0;
        res_cnt_d   = cnt_q;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  assign out_valid_d = load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_val_q   <= top_val_d;
    top_min_q   <= top_min_d;
    res_top_q   <= res_top_d;
    res_min_q   <= res_min_d;
    res_empty_q <= res_empty_d;
    res_ovf_q   <= res_ovf_d;
    res_cnt_q   <= res_cnt_d;
  end

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.top_value   = res_top_q;
  assign out_o.min_value   = res_min_q;
  assign out_o.stack_empty = res_empty_q;
  assign out_o.overflow    = res_ovf_q;
  assign out_o.entry_count = EntryW'(res_cnt_q);

endmodule

`default_nettype wire
